// ===== rtl/osm_pkg.sv =====
`timescale 1ns / 1ps

package osm_pkg;

	// Default sizes of the store.
	localparam int CAPACITY_DEF   = 64;
	localparam int COUNT_BITS_DEF = 16;
	localparam int KEY_BITS_DEF   = 32;

	// Port field widths.
	localparam int FUNC_W   = 4;
	localparam int KEYIN_W  = 32;
	localparam int AMOUNT_W = 16;
	localparam int RANK_W   = 22;
	localparam int STATUS_W = 3;
	localparam int VALUE_W  = 32;
	localparam int TALLY_W  = 22;
	localparam int TOTAL_W  = 22;
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 80;

	// Operation codes.
	localparam logic [FUNC_W-1:0] F_INSERT   = 4'd0;
	localparam logic [FUNC_W-1:0] F_ERASE    = 4'd1;
	localparam logic [FUNC_W-1:0] F_ERASEKEY = 4'd2;
	localparam logic [FUNC_W-1:0] F_KTH      = 4'd3;
	localparam logic [FUNC_W-1:0] F_COUNT    = 4'd4;
	localparam logic [FUNC_W-1:0] F_GREATER  = 4'd5;
	localparam logic [FUNC_W-1:0] F_LESS     = 4'd6;
	localparam logic [FUNC_W-1:0] F_BIGGEST  = 4'd7;
	localparam logic [FUNC_W-1:0] F_SMALLEST = 4'd8;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANK   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_SAT    = 3'd5;

	// Commands broadcast to the cells.
	localparam logic [2:0] CMD_NONE     = 3'd0;
	localparam logic [2:0] CMD_INSERT   = 3'd1;
	localparam logic [2:0] CMD_REMOVE   = 3'd2;
	localparam logic [2:0] CMD_SETCNT   = 3'd3;
	localparam logic [2:0] CMD_COLLAPSE = 3'd4;

endpackage

// ===== rtl/osm_cell.sv =====
`timescale 1ns / 1ps

// One slot of the sorted store, plus one stage of the scan chain.
module osm_cell #(
	parameter int KB = osm_pkg::KEY_BITS_DEF,
	parameter int CB = osm_pkg::COUNT_BITS_DEF,
	parameter int TW = osm_pkg::COUNT_BITS_DEF + 7,
	parameter type ctrl_t = logic,
	parameter type chain_t = logic
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ctrl_t         ctrl,
	input  logic [KB-1:0] lft_key,
	input  logic [CB-1:0] lft_cnt,
	input  logic          lft_valid,
	input  logic          lft_lt,
	input  logic [KB-1:0] rgt_key,
	input  logic [CB-1:0] rgt_cnt,
	input  logic          rgt_valid,
	input  chain_t        chain_in,
	output chain_t        chain_out,
	output logic [KB-1:0] key,
	output logic [CB-1:0] cnt,
	output logic          valid,
	output logic          lt
);

	localparam int RW = (TW > osm_pkg::RANK_W) ? TW : osm_pkg::RANK_W;

	logic [KB-1:0] key_q;
	logic [CB-1:0] cnt_q;
	logic          valid_q;
	logic          eq;
	logic          gt;
	logic [TW-1:0] contrib;
	logic [TW-1:0] sum;
	chain_t        nxt;
	chain_t        chain_q;

	assign lt = valid_q && ($signed(key_q) < $signed(ctrl.key));
	assign eq = valid_q && (key_q == ctrl.key);
	assign gt = valid_q && ($signed(key_q) > $signed(ctrl.key));

	always_comb begin
		case (ctrl.func)
			osm_pkg::F_KTH:      contrib = valid_q ? TW'(cnt_q) : '0;
			osm_pkg::F_INSERT,
			osm_pkg::F_ERASE,
			osm_pkg::F_ERASEKEY,
			osm_pkg::F_COUNT:    contrib = eq ? TW'(cnt_q) : '0;
			osm_pkg::F_GREATER:  contrib = gt ? TW'(cnt_q) : '0;
			osm_pkg::F_LESS:     contrib = lt ? TW'(cnt_q) : '0;
			default:             contrib = '0;
		endcase
		sum = chain_in.acc + contrib;
		nxt = chain_in;
		nxt.acc = sum;
		nxt.found = chain_in.found | eq;
		if (!chain_in.kdone && valid_q && (RW'(ctrl.rank) <= RW'(sum))) begin
			nxt.kdone = 1'b1;
			nxt.kkey = key_q;
		end
		if (valid_q) begin
			nxt.lkey = key_q;
		end
	end

	always_ff @(posedge clk) begin
		chain_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctrl.cmd)
				osm_pkg::CMD_INSERT: begin
					if (!lt) begin
						if (lft_lt) begin
							valid_q <= 1'b1;
						end else begin
							valid_q <= lft_valid;
						end
					end
				end
				osm_pkg::CMD_REMOVE: begin
					if (!lt) begin
						valid_q <= rgt_valid;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			osm_pkg::CMD_INSERT: begin
				if (!lt) begin
					if (lft_lt) begin
						key_q <= ctrl.key;
						cnt_q <= ctrl.cnt_new;
					end else begin
						key_q <= lft_key;
						cnt_q <= lft_cnt;
					end
				end
			end
			osm_pkg::CMD_REMOVE: begin
				if (!lt) begin
					key_q <= rgt_key;
					cnt_q <= rgt_cnt;
				end
			end
			osm_pkg::CMD_SETCNT: begin
				if (eq) begin
					cnt_q <= ctrl.cnt_new;
				end
			end
			osm_pkg::CMD_COLLAPSE: begin
				if (valid_q) begin
					cnt_q <= CB'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign chain_out = chain_q;
	assign key = key_q;
	assign cnt = cnt_q;
	assign valid = valid_q;

endmodule

// ===== rtl/order_statistic_multiset.sv =====
// Operation: an accepted word takes the sequencer from idle through scan to commit, where
// its result word is registered; the scan chain moves one cell per cycle and must pass all
// CAPACITY cells before an operation can be committed. No new word is taken before its commit.
// Reset: arst_n asynchronously empties the store, clears the element total and sets
// allow_duplicates to one; no clearing pass is needed.
`timescale 1ns / 1ps

module order_statistic_multiset #(
	parameter int CAPACITY   = osm_pkg::CAPACITY_DEF,
	parameter int COUNT_BITS = osm_pkg::COUNT_BITS_DEF,
	parameter int KEY_BITS   = osm_pkg::KEY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Input words.
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// Fields from bit 0 up: key[31:0], amount[47:32], rank[69:48], zero pad.
	input  logic [osm_pkg::S_DATA_W-1:0] s_tdata,
	// Fields from bit 0 up: func[3:0].
	input  logic [osm_pkg::FUNC_W-1:0]   s_tuser,
	// Result words.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// Fields from bit 0 up: status[2:0], value[34:3], tally[56:35], total[78:57],
	// zero pad.
	output logic [osm_pkg::M_DATA_W-1:0] m_tdata,
	// The allow_duplicates register.
	input  logic                          cfg_wen,
	input  logic                          cfg_wdata
);

	localparam int KB = KEY_BITS;
	localparam int CB = COUNT_BITS;
	localparam int OW = $clog2(CAPACITY + 1);
	localparam int TW = CB + OW;
	localparam int WW = ((TW > 33) ? TW : 33) + 1;
	localparam int SW = $clog2(CAPACITY);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_COMMIT = 2'd2;

	// Broadcast from the sequencer to every cell.
	typedef struct packed {
		logic [KB-1:0]               key;
		logic [osm_pkg::RANK_W-1:0] rank;
		logic [osm_pkg::FUNC_W-1:0] func;
		logic [2:0]                  cmd;
		logic [CB-1:0]               cnt_new;
	} ctrl_t;

	// Carried from each cell to its right-hand neighbour every cycle.
	typedef struct packed {
		logic [TW-1:0] acc;
		logic          found;
		logic          kdone;
		logic [KB-1:0] kkey;
		logic [KB-1:0] lkey;
	} chain_t;

	logic [1:0]                  state_q;
	logic [SW-1:0]               scan_q;
	logic                        dup_q;
	logic [OW-1:0]               occ_q;
	logic [TW-1:0]               total_q;
	logic [osm_pkg::FUNC_W-1:0] func_q;
	logic [KB-1:0]               key_q;
	logic [osm_pkg::AMOUNT_W-1:0] amt_q;
	logic [osm_pkg::RANK_W-1:0] rank_q;
	logic                        m_valid_q;
	logic [osm_pkg::M_DATA_W-1:0] m_data_q;

	logic [KB-1:0] key_a   [CAPACITY];
	logic [CB-1:0] cnt_a   [CAPACITY];
	logic          valid_a [CAPACITY];
	logic          lt_a    [CAPACITY];
	chain_t        chain_w [CAPACITY+1];
	ctrl_t         ctrl;

	logic          accept;
	logic          commit;
	logic [63:0]   key_wide;
	chain_t        tail;
	logic [WW-1:0] cnt_p;
	logic [WW-1:0] a_w;
	logic [WW-1:0] cmax;
	logic [WW-1:0] c_w;
	logic [2:0]    cmd_c;
	logic [CB-1:0] cnt_c;
	logic [osm_pkg::STATUS_W-1:0] status_c;
	logic [KB-1:0] vkey_c;
	logic          vsel_c;
	logic [TW-1:0] total_c;
	logic [OW-1:0] occ_c;
	logic [63:0]   tally_wide;
	logic [63:0]   total_wide;
	logic [63:0]   value_wide;
	logic [osm_pkg::TALLY_W-1:0] tally_c;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	// A finished result waits in the output register; the commit holds off until it
	// has been taken.
	assign commit = (state_q == S_COMMIT) && (!m_valid_q || m_tready);

	// The 32-bit key is sign extended, then cut to the stored key width.
	assign key_wide = 64'($signed(s_tdata[osm_pkg::KEYIN_W-1:0]));

	assign chain_w[0] = '0;
	assign tail = chain_w[CAPACITY];

	always_comb begin
		ctrl.key = key_q;
		ctrl.rank = rank_q;
		ctrl.func = func_q;
		ctrl.cmd = osm_pkg::CMD_NONE;
		ctrl.cnt_new = cnt_c;
		if (commit) begin
			ctrl.cmd = cmd_c;
		end else if (cfg_wen && !cfg_wdata) begin
			// Dropping duplicates collapses every stored count to one.
			ctrl.cmd = osm_pkg::CMD_COLLAPSE;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [KB-1:0] lk;
			logic [CB-1:0] lc;
			logic          lv;
			logic          ll;
			logic [KB-1:0] rk;
			logic [CB-1:0] rc;
			logic          rv;
			if (gi == 0) begin : g_first
				// Anything left of the first slot counts as a smaller key.
				assign lk = '0;
				assign lc = '0;
				assign lv = 1'b0;
				assign ll = 1'b1;
			end else begin : g_mid
				assign lk = key_a[gi-1];
				assign lc = cnt_a[gi-1];
				assign lv = valid_a[gi-1];
				assign ll = lt_a[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign rk = '0;
				assign rc = '0;
				assign rv = 1'b0;
			end else begin : g_inner
				assign rk = key_a[gi+1];
				assign rc = cnt_a[gi+1];
				assign rv = valid_a[gi+1];
			end
			osm_cell #(
				.KB(KB),
				.CB(CB),
				.TW(TW),
				.ctrl_t(ctrl_t),
				.chain_t(chain_t)
			) u_cell (
				.clk(clk),
				.arst_n(arst_n),
				.ctrl(ctrl),
				.lft_key(lk),
				.lft_cnt(lc),
				.lft_valid(lv),
				.lft_lt(ll),
				.rgt_key(rk),
				.rgt_cnt(rc),
				.rgt_valid(rv),
				.chain_in(chain_w[gi]),
				.chain_out(chain_w[gi+1]),
				.key(key_a[gi]),
				.cnt(cnt_a[gi]),
				.valid(valid_a[gi]),
				.lt(lt_a[gi])
			);
		end
	endgenerate

	// Commit decision, made from the settled end of the chain. For the update
	// operations the chain sum is the count held by the matching key.
	always_comb begin
		cnt_p = WW'(tail.acc);
		a_w = dup_q ? WW'(amt_q) : WW'(1);
		cmax = WW'((64'd1 << CB) - 64'd1);
		c_w = '0;
		cmd_c = osm_pkg::CMD_NONE;
		status_c = osm_pkg::ST_OK;
		vkey_c = '0;
		vsel_c = 1'b0;
		total_c = total_q;
		occ_c = occ_q;
		tally_c = '0;
		tally_wide = 64'(tail.acc);
		case (func_q)
			osm_pkg::F_INSERT: begin
				if (tail.found) begin
					if (dup_q) begin
						c_w = cnt_p + a_w;
						if (c_w > cmax) begin
							c_w = cmax;
							status_c = osm_pkg::ST_SAT;
						end
						cmd_c = osm_pkg::CMD_SETCNT;
						total_c = total_q + TW'(c_w) - TW'(cnt_p);
					end
				end else if (a_w != '0) begin
					if (valid_a[CAPACITY-1]) begin
						status_c = osm_pkg::ST_FULL;
					end else begin
						c_w = a_w;
						if (c_w > cmax) begin
							c_w = cmax;
							status_c = osm_pkg::ST_SAT;
						end
						cmd_c = osm_pkg::CMD_INSERT;
						occ_c = occ_q + OW'(1);
						total_c = total_q + TW'(c_w);
					end
				end
			end
			osm_pkg::F_ERASE: begin
				if (!tail.found) begin
					status_c = osm_pkg::ST_ABSENT;
				end else if (cnt_p <= WW'(amt_q)) begin
					cmd_c = osm_pkg::CMD_REMOVE;
					occ_c = occ_q - OW'(1);
					total_c = total_q - TW'(cnt_p);
				end else begin
					c_w = cnt_p - WW'(amt_q);
					cmd_c = osm_pkg::CMD_SETCNT;
					total_c = total_q - TW'(amt_q);
				end
			end
			osm_pkg::F_ERASEKEY: begin
				if (!tail.found) begin
					status_c = osm_pkg::ST_ABSENT;
				end else begin
					cmd_c = osm_pkg::CMD_REMOVE;
					occ_c = occ_q - OW'(1);
					total_c = total_q - TW'(cnt_p);
				end
			end
			osm_pkg::F_KTH: begin
				if ((rank_q == '0) || (WW'(rank_q) > WW'(total_q))) begin
					status_c = osm_pkg::ST_RANK;
				end else begin
					vkey_c = tail.kkey;
					vsel_c = 1'b1;
				end
			end
			osm_pkg::F_COUNT,
			osm_pkg::F_GREATER,
			osm_pkg::F_LESS: begin
				tally_c = tally_wide[osm_pkg::TALLY_W-1:0];
			end
			osm_pkg::F_BIGGEST: begin
				if (!valid_a[0]) begin
					status_c = osm_pkg::ST_EMPTY;
				end else begin
					vkey_c = tail.lkey;
					vsel_c = 1'b1;
				end
			end
			osm_pkg::F_SMALLEST: begin
				if (!valid_a[0]) begin
					status_c = osm_pkg::ST_EMPTY;
				end else begin
					vkey_c = key_a[0];
					vsel_c = 1'b1;
				end
			end
			default: begin
			end
		endcase
		cnt_c = CB'(c_w);
	end

	assign value_wide = vsel_c ? 64'($signed(vkey_c)) : 64'd0;
	assign total_wide = 64'(total_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			scan_q <= '0;
			dup_q <= 1'b1;
			occ_q <= '0;
			total_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_wen) begin
				dup_q <= cfg_wdata;
				if (!cfg_wdata) begin
					total_q <= TW'(occ_q);
				end
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						scan_q <= '0;
					end
				end
				S_SCAN: begin
					// Wait for the chain to ripple through every cell.
					scan_q <= scan_q + SW'(1);
					if (scan_q == SW'(CAPACITY - 1)) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (commit) begin
						state_q <= S_IDLE;
						occ_q <= occ_c;
						total_q <= total_c;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= s_tuser;
			key_q <= key_wide[KB-1:0];
			amt_q <= s_tdata[osm_pkg::KEYIN_W +: osm_pkg::AMOUNT_W];
			rank_q <= s_tdata[osm_pkg::KEYIN_W + osm_pkg::AMOUNT_W +: osm_pkg::RANK_W];
		end
		if (commit) begin
			m_data_q <= {1'b0, total_wide[osm_pkg::TOTAL_W-1:0], tally_c,
				value_wide[osm_pkg::VALUE_W-1:0], status_c};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;

endmodule

// ===== rtl/osm_checker.sv =====
`timescale 1ns / 1ps

module osm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [osm_pkg::M_DATA_W-1:0] m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken while an operation is in progress");

	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == osm_pkg::ST_EMPTY) |-> (m_tdata[78:57] == '0))
		else $error("empty set reported with a non-zero total");

endmodule

bind order_statistic_multiset osm_checker u_osm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
